// ----- rtl/complex_arithmetic_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Property checked outside reset.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cau_pkg.sv -----
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // quotient bits kept before the overflow decision
  localparam int QBITS = WORD_BITS + 1;
  localparam int NUM_CELLS = QBITS;
  // wide signed intermediates
  localparam int PW = 2 * WORD_BITS + 2;
  // divider remainder / shifted divisor width
  localparam int REMW = 3 * WORD_BITS + 1;

  localparam logic [2:0] MODE_MUL  = 3'd0;
  localparam logic [2:0] MODE_CONJ = 3'd1;
  localparam logic [2:0] MODE_DIV  = 3'd2;
  localparam logic [2:0] MODE_ADD  = 3'd3;
  localparam logic [2:0] MODE_SUB  = 3'd4;
  localparam logic [2:0] MODE_SMUL = 3'd5;
  localparam logic [2:0] MODE_SDIV = 3'd6;
  localparam logic [2:0] MODE_MOD  = 3'd7;

  localparam logic [1:0] ERR_OK  = 2'd0;
  localparam logic [1:0] ERR_OVF = 2'd1;
  localparam logic [1:0] ERR_DZ  = 2'd2;

  // Data carried from cell to cell
  typedef struct packed {
    logic                      valid;
    logic                      is_div;
    logic                      is_sqrt;
    logic                      dz;
    logic                      ovf_r;
    logic                      ovf_i;
    logic                      neg_r;
    logic                      neg_i;
    logic                      nz_r;
    logic                      nz_i;
    logic signed [PW-1:0]      pass_r;
    logic signed [PW-1:0]      pass_i;
    logic [REMW-1:0]           rem_r;
    logic [REMW-1:0]           rem_i;
    logic [REMW-1:0]           dsh;
    logic [QBITS-1:0]          q_r;
    logic [QBITS-1:0]          q_i;
    logic [2*WORD_BITS-1:0]    op;
    logic [PW-1:0]             res;
    logic [PW-1:0]             one;
  } cell_t;

  function automatic logic signed [PW-1:0] ext_word(input logic signed [WORD_BITS-1:0] x);
    return {{(PW-WORD_BITS){x[WORD_BITS-1]}}, x};
  endfunction

  function automatic logic signed [PW-1:0] ext_prod(input logic signed [2*WORD_BITS-1:0] x);
    return {{(PW-2*WORD_BITS){x[2*WORD_BITS-1]}}, x};
  endfunction

endpackage

// ----- rtl/cau_front.sv -----
module cau_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_fire,
  input  logic [2:0]                             mode,
  input  logic signed [cau_pkg::WORD_BITS-1:0]   a_real,
  input  logic signed [cau_pkg::WORD_BITS-1:0]   a_imag,
  input  logic signed [cau_pkg::WORD_BITS-1:0]   b_real,
  input  logic signed [cau_pkg::WORD_BITS-1:0]   b_imag,
  input  logic signed [cau_pkg::WORD_BITS-1:0]   scalar_value,
  output cau_pkg::cell_t                         cell_out
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int PW = cau_pkg::PW;
  localparam int RW = cau_pkg::REMW;
  localparam int FB = cau_pkg::FRAC_BITS;

  // stage A: products
  logic                  valid_a;
  logic [2:0]            mode_a;
  logic signed [W-1:0]   ar_a, ai_a, br_a, bi_a, c_a;
  logic signed [2*W-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [W-1:0]   x4, y4, x5, y5;

  always_comb begin
    if (mode == cau_pkg::MODE_SMUL) begin
      x4 = scalar_value; y4 = a_real; x5 = scalar_value; y5 = a_imag;
    end else if (mode == cau_pkg::MODE_MOD) begin
      x4 = a_real; y4 = a_real; x5 = a_imag; y5 = a_imag;
    end else begin
      x4 = b_real; y4 = b_real; x5 = b_imag; y5 = b_imag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (en) begin
      valid_a <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_a <= mode;
      ar_a <= a_real; ai_a <= a_imag; br_a <= b_real; bi_a <= b_imag;
      c_a <= scalar_value;
      p0 <= a_real * b_real;
      p1 <= a_imag * b_imag;
      p2 <= a_real * b_imag;
      p3 <= a_imag * b_real;
      p4 <= x4 * y4;
      p5 <= x5 * y5;
    end
  end

  // stage B: sums, direct results, divider operands
  logic                  valid_b, dneg_b;
  logic [2:0]            mode_b;
  logic signed [PW-1:0]  pass_r_b, pass_i_b, num_r_b, num_i_b;
  logic [2*W-1:0]        den_b, sq_b;
  logic signed [PW-1:0]  pass_r_next, pass_i_next, num_r_next, num_i_next, ce;
  logic [2*W-1:0]        den_next, psum;

  always_comb begin
    ce   = cau_pkg::ext_word(c_a);
    psum = p4 + p5;
    pass_r_next = '0;
    pass_i_next = '0;
    num_r_next  = cau_pkg::ext_prod(p0) + cau_pkg::ext_prod(p1);
    num_i_next  = cau_pkg::ext_prod(p3) - cau_pkg::ext_prod(p2);
    den_next    = psum;
    case (mode_a)
      cau_pkg::MODE_MUL: begin
        pass_r_next = (cau_pkg::ext_prod(p0) - cau_pkg::ext_prod(p1)) >>> FB;
        pass_i_next = (cau_pkg::ext_prod(p2) + cau_pkg::ext_prod(p3)) >>> FB;
      end
      cau_pkg::MODE_CONJ: begin
        pass_r_next = cau_pkg::ext_word(ar_a);
        pass_i_next = -cau_pkg::ext_word(ai_a);
      end
      cau_pkg::MODE_ADD: begin
        pass_r_next = cau_pkg::ext_word(ar_a) + cau_pkg::ext_word(br_a);
        pass_i_next = cau_pkg::ext_word(ai_a) + cau_pkg::ext_word(bi_a);
      end
      cau_pkg::MODE_SUB: begin
        pass_r_next = cau_pkg::ext_word(ar_a) - cau_pkg::ext_word(br_a);
        pass_i_next = cau_pkg::ext_word(ai_a) - cau_pkg::ext_word(bi_a);
      end
      cau_pkg::MODE_SMUL: begin
        pass_r_next = cau_pkg::ext_prod(p4) >>> FB;
        pass_i_next = cau_pkg::ext_prod(p5) >>> FB;
      end
      cau_pkg::MODE_SDIV: begin
        num_r_next = cau_pkg::ext_word(ar_a);
        num_i_next = cau_pkg::ext_word(ai_a);
        den_next   = ce[PW-1] ? (2*W)'(-ce) : (2*W)'(ce);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (en) begin
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_b   <= mode_a;
      pass_r_b <= pass_r_next;
      pass_i_b <= pass_i_next;
      num_r_b  <= num_r_next;
      num_i_b  <= num_i_next;
      den_b    <= den_next;
      dneg_b   <= (mode_a == cau_pkg::MODE_SDIV) && c_a[W-1];
      sq_b     <= psum;
    end
  end

  // divider and root setup for the first cell
  logic [PW-1:0] mag_r, mag_i;
  logic [RW-1:0] nsh_r, nsh_i, dext;

  always_comb begin
    mag_r = num_r_b[PW-1] ? PW'(-num_r_b) : PW'(num_r_b);
    mag_i = num_i_b[PW-1] ? PW'(-num_i_b) : PW'(num_i_b);
    nsh_r = RW'(mag_r) << FB;
    nsh_i = RW'(mag_i) << FB;
    dext  = RW'(den_b);
    cell_out.valid   = valid_b;
    cell_out.is_div  = (mode_b == cau_pkg::MODE_DIV) || (mode_b == cau_pkg::MODE_SDIV);
    cell_out.is_sqrt = (mode_b == cau_pkg::MODE_MOD);
    cell_out.dz      = (den_b == '0);
    cell_out.ovf_r   = nsh_r >= (dext << cau_pkg::QBITS);
    cell_out.ovf_i   = nsh_i >= (dext << cau_pkg::QBITS);
    cell_out.neg_r   = num_r_b[PW-1] ^ dneg_b;
    cell_out.neg_i   = num_i_b[PW-1] ^ dneg_b;
    cell_out.nz_r    = (num_r_b != '0);
    cell_out.nz_i    = (num_i_b != '0);
    cell_out.pass_r  = pass_r_b;
    cell_out.pass_i  = pass_i_b;
    cell_out.rem_r   = nsh_r;
    cell_out.rem_i   = nsh_i;
    cell_out.dsh     = dext << (cau_pkg::QBITS - 1);
    cell_out.q_r     = '0;
    cell_out.q_i     = '0;
    cell_out.op      = sq_b;
    cell_out.res     = '0;
    cell_out.one     = PW'(1) << (2 * (cau_pkg::NUM_CELLS - 1));
  end

endmodule

// ----- rtl/cau_cell.sv -----
module cau_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cau_pkg::cell_t cell_in,
  output cau_pkg::cell_t cell_out
);

  localparam int PW = cau_pkg::PW;
  localparam int OW = 2 * cau_pkg::WORD_BITS;

  cau_pkg::cell_t                    cell_next;
  logic [PW-1:0]                     trial;
  logic                              valid;
  logic [$bits(cau_pkg::cell_t)-2:0] body;

  // one quotient bit for each part and one root bit
  always_comb begin
    cell_next = cell_in;
    if (cell_in.rem_r >= cell_in.dsh) begin
      cell_next.rem_r = cell_in.rem_r - cell_in.dsh;
      cell_next.q_r   = {cell_in.q_r[cau_pkg::QBITS-2:0], 1'b1};
    end else begin
      cell_next.q_r   = {cell_in.q_r[cau_pkg::QBITS-2:0], 1'b0};
    end
    if (cell_in.rem_i >= cell_in.dsh) begin
      cell_next.rem_i = cell_in.rem_i - cell_in.dsh;
      cell_next.q_i   = {cell_in.q_i[cau_pkg::QBITS-2:0], 1'b1};
    end else begin
      cell_next.q_i   = {cell_in.q_i[cau_pkg::QBITS-2:0], 1'b0};
    end
    cell_next.dsh = cell_in.dsh >> 1;
    trial = cell_in.res + cell_in.one;
    if (PW'(cell_in.op) >= trial) begin
      cell_next.op  = cell_in.op - trial[OW-1:0];
      cell_next.res = (cell_in.res >> 1) + cell_in.one;
    end else begin
      cell_next.res = cell_in.res >> 1;
    end
    cell_next.one = cell_in.one >> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      body <= cell_next[$bits(cau_pkg::cell_t)-2:0];
    end
  end

  // valid is the top field of the cell struct
  assign cell_out = {valid, body};

endmodule

// ----- rtl/cau_back.sv -----
module cau_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cau_pkg::cell_t                        cell_in,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  en,
  output logic signed [cau_pkg::WORD_BITS-1:0]  result_real,
  output logic signed [cau_pkg::WORD_BITS-1:0]  result_imag,
  output logic [1:0]                            error_flag
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int PW = cau_pkg::PW;
  localparam logic signed [PW-1:0] VMAX = PW'((64'(1) << (W - 1)) - 64'(1));
  localparam logic signed [PW-1:0] VMIN = -(PW'(64'(1) << (W - 1)));
  localparam logic signed [PW-1:0] BIG  = PW'(64'(1) << (W + 1));

  logic signed [PW-1:0] v_r, v_i, m_r, m_i;
  logic signed [W-1:0]  s_r, s_i;
  logic                 o_r, o_i;
  logic [1:0]           err;

  // final value for each part, then saturation
  always_comb begin
    m_r = cell_in.ovf_r ? BIG : PW'(cell_in.q_r);
    m_i = cell_in.ovf_i ? BIG : PW'(cell_in.q_i);
    if (cell_in.is_div && cell_in.dz) begin
      v_r = !cell_in.nz_r ? '0 : (cell_in.neg_r ? -BIG : BIG);
      v_i = !cell_in.nz_i ? '0 : (cell_in.neg_i ? -BIG : BIG);
    end else if (cell_in.is_div) begin
      v_r = cell_in.neg_r ? -m_r : m_r;
      v_i = cell_in.neg_i ? -m_i : m_i;
    end else if (cell_in.is_sqrt) begin
      v_r = cell_in.res;
      v_i = '0;
    end else begin
      v_r = cell_in.pass_r;
      v_i = cell_in.pass_i;
    end
    o_r = (v_r > VMAX) || (v_r < VMIN);
    o_i = (v_i > VMAX) || (v_i < VMIN);
    s_r = (v_r > VMAX) ? W'(VMAX) : ((v_r < VMIN) ? W'(VMIN) : W'(v_r));
    s_i = (v_i > VMAX) ? W'(VMAX) : ((v_i < VMIN) ? W'(VMIN) : W'(v_i));
    if (cell_in.is_div && cell_in.dz) begin
      err = cau_pkg::ERR_DZ;
    end else if (o_r || o_i) begin
      err = cau_pkg::ERR_OVF;
    end else begin
      err = cau_pkg::ERR_OK;
    end
  end

  // output register; chain advances whenever it can be freed
  assign en = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_real <= s_r;
      result_imag <= s_i;
      error_flag  <= err;
    end
  end

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | mode, a_real, a_imag, b_real, b_imag, scalar_value
// output  | out_valid / out_ready| result_real, result_imag, error_flag
//
// One item per cycle unless a held result stalls the chain; each item passes the
// product stage, sum stage, 33 divide/root cells and output register in turn.
// The 33-cell chain yields one quotient bit per part and one root bit per cell.
// Synchronous reset clears all valid flags; the data registers are not reset.
// A held result stalls the whole chain; in_ready is low only then.
module complex_arithmetic_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0]                            mode,
  input  logic signed [cau_pkg::WORD_BITS-1:0]  a_real,
  input  logic signed [cau_pkg::WORD_BITS-1:0]  a_imag,
  input  logic signed [cau_pkg::WORD_BITS-1:0]  b_real,
  input  logic signed [cau_pkg::WORD_BITS-1:0]  b_imag,
  input  logic signed [cau_pkg::WORD_BITS-1:0]  scalar_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cau_pkg::WORD_BITS-1:0]  result_real,
  output logic signed [cau_pkg::WORD_BITS-1:0]  result_imag,
  output logic [1:0]                            error_flag
);

  logic           en;
  cau_pkg::cell_t chain [cau_pkg::NUM_CELLS+1];

  assign in_ready = en;

  cau_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_fire      (in_valid && en),
    .mode         (mode),
    .a_real       (a_real),
    .a_imag       (a_imag),
    .b_real       (b_real),
    .b_imag       (b_imag),
    .scalar_value (scalar_value),
    .cell_out     (chain[0])
  );

  // divide / root cells
  for (genvar k = 0; k < cau_pkg::NUM_CELLS; k++) begin : g_cell
    cau_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  cau_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cell_in     (chain[cau_pkg::NUM_CELLS]),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .en          (en),
    .result_real (result_real),
    .result_imag (result_imag),
    .error_flag  (error_flag)
  );

endmodule

// ----- rtl/cau_checker.sv -----
`include "complex_arithmetic_unit_macros.svh"

module cau_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [cau_pkg::WORD_BITS-1:0] result_real,
  input logic [1:0]                           error_flag
);

  // a held result stays put
  `CAU_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(result_real), "result dropped")
  // the unused error code never appears
  `CAU_ASSERT(a_err, out_valid |-> error_flag != 2'd3, "bad error code")
  // input side is open whenever the output is free
  `CAU_ASSERT(a_rdy, !out_valid |-> in_ready, "stall without a held result")
  // reset empties the output
  `CAU_ASSERT_ALWAYS(a_rst, rst |=> !out_valid, "output valid after reset")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_real (result_real),
  .error_flag  (error_flag)
);
